// ===== rtl/lbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared types and codes of the LRU buffer replacer: request and response
// payloads, operation and error codes, controller state, command and status.
// ----------------------------------------------------------------------------
package lbr_pkg;

  localparam int ID_BITS    = 6;
  localparam int COUNT_BITS = 7;
  localparam int KIND_BITS  = 3;
  localparam int ERR_BITS   = 2;

  // operation codes
  localparam logic [KIND_BITS-1:0] KIND_RECORD    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_SET_EVICT = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_EVICT     = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE    = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_PEEK      = 3'd4;

  // error codes
  localparam logic [ERR_BITS-1:0] ERR_NONE        = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_RANGE       = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_UNEVICTABLE = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_UNTRACKED   = 2'd3;

  localparam logic [COUNT_BITS-1:0] FRAME_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [ID_BITS-1:0]   frame_id;
    logic                 evictable;
  } lbr_req_t;

  typedef struct packed {
    logic                  ok;
    logic [ID_BITS-1:0]    victim_frame;
    logic [ERR_BITS-1:0]   error;
    logic [COUNT_BITS-1:0] evictable_total;
  } lbr_resp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lbr_state_t;

  typedef struct packed {
    logic capture;    // latch request, rewind the scan
    logic scan_step;  // advance the victim scan by one frame
    logic commit;     // apply the update and load the response
  } lbr_cmd_t;

  typedef struct packed {
    logic scan_kind;  // latched request is evict or peek
    logic scan_done;  // every frame compared
    logic out_free;   // response register can take a new response
  } lbr_stat_t;

endpackage

// ===== rtl/lbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbr_ctrl
// Sequencer of the LRU buffer replacer: accept, scan, commit.
// ----------------------------------------------------------------------------
module lbr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lbr_pkg::lbr_stat_t stat,
  output lbr_pkg::lbr_cmd_t  cmd
);
  import lbr_pkg::*;

  lbr_state_t state;
  lbr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat.scan_kind || stat.scan_done) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_COMMIT: begin
        // hold until the response register frees up
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lbr_datapath.sv =====
// ----------------------------------------------------------------------------
// lbr_datapath
// Frame table, stamp memory, access clock, victim scan and response register.
// ----------------------------------------------------------------------------
module lbr_datapath #(
  parameter int FRAMES     = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [lbr_pkg::COUNT_BITS-1:0]   cfg_data,
  input  lbr_pkg::lbr_req_t                req,
  input  lbr_pkg::lbr_cmd_t                cmd,
  output lbr_pkg::lbr_stat_t               stat,
  output logic                             resp_valid,
  input  logic                             resp_stall,
  output lbr_pkg::lbr_resp_t               resp
);
  import lbr_pkg::*;

  localparam int ID_W  = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);

  // latched request
  logic [KIND_BITS-1:0] kind_q;
  logic [ID_BITS-1:0]   id_q;
  logic                 mark_q;

  logic [COUNT_BITS-1:0] frame_count;
  logic [FRAMES-1:0]     tracked;
  logic [FRAMES-1:0]     can_evict;
  logic [STAMP_BITS-1:0] access_clock;
  logic [COUNT_BITS-1:0] evict_cnt;

  logic [STAMP_BITS-1:0] stamp_mem [FRAMES];
  logic [STAMP_BITS-1:0] stamp_q;

  // scan pipeline
  logic [CNT_W-1:0]      scan_addr;
  logic                  rd_valid;
  logic                  rd_cand;
  logic [ID_W-1:0]       rd_idx;
  logic                  found;
  logic [STAMP_BITS-1:0] best;
  logic [ID_W-1:0]       best_idx;

  // commit logic
  logic [31:0]           id_wide;
  logic [ID_W-1:0]       idx;
  logic                  in_range;
  logic [31:0]           best_wide;
  logic [FRAMES-1:0]     tracked_next;
  logic [FRAMES-1:0]     can_evict_next;
  logic [COUNT_BITS-1:0] evict_cnt_next;
  logic [STAMP_BITS-1:0] access_clock_next;
  logic                  mem_we;
  lbr_resp_t             resp_next;

  assign id_wide   = 32'(id_q);
  assign idx       = id_wide[ID_W-1:0];
  assign in_range  = ({1'b0, id_q} < frame_count) && (id_wide < 32'(FRAMES));
  assign best_wide = 32'(best_idx);

  assign stat.scan_kind = (kind_q == KIND_EVICT) || (kind_q == KIND_PEEK);
  assign stat.scan_done = (scan_addr == CNT_W'(FRAMES)) && !rd_valid;
  assign stat.out_free  = !resp_valid || !resp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
    end else if (cfg_valid) begin
      frame_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= req.kind;
      id_q   <= req.frame_id;
      mark_q <= req.evictable;
    end
  end

  // stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we && cmd.commit) begin
      stamp_mem[idx] <= access_clock_next;
    end
    stamp_q <= stamp_mem[scan_addr[ID_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.capture) begin
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        if (scan_addr != CNT_W'(FRAMES)) begin
          rd_valid  <= 1'b1;
          scan_addr <= scan_addr + CNT_W'(1);
        end else begin
          rd_valid <= 1'b0;
        end
      end
      // oldest stamp wins, strict compare keeps the lower id on ties
      if (rd_valid && rd_cand && (!found || (stamp_q < best))) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && (scan_addr != CNT_W'(FRAMES))) begin
      rd_idx  <= scan_addr[ID_W-1:0];
      rd_cand <= tracked[scan_addr[ID_W-1:0]] && can_evict[scan_addr[ID_W-1:0]];
    end
    if (rd_valid && rd_cand && (!found || (stamp_q < best))) begin
      best     <= stamp_q;
      best_idx <= rd_idx;
    end
  end

  always_comb begin
    tracked_next      = tracked;
    can_evict_next    = can_evict;
    evict_cnt_next    = evict_cnt;
    access_clock_next = access_clock;
    mem_we            = 1'b0;
    resp_next         = '0;
    case (kind_q)
      KIND_RECORD: begin
        if (access_clock != {STAMP_BITS{1'b1}}) begin
          access_clock_next = access_clock + STAMP_BITS'(1);
        end
        if (!in_range) begin
          resp_next.error = ERR_RANGE;
        end else begin
          if (!tracked[idx]) begin
            tracked_next[idx]   = 1'b1;
            can_evict_next[idx] = 1'b0;
          end
          mem_we       = 1'b1;
          resp_next.ok = 1'b1;
        end
      end
      KIND_SET_EVICT: begin
        if (!in_range) begin
          resp_next.error = ERR_RANGE;
        end else if (!tracked[idx]) begin
          resp_next.error = ERR_UNTRACKED;
        end else begin
          if (can_evict[idx] != mark_q) begin
            if (mark_q) begin
              evict_cnt_next = evict_cnt + COUNT_BITS'(1);
            end else if (evict_cnt != '0) begin
              evict_cnt_next = evict_cnt - COUNT_BITS'(1);
            end
            can_evict_next[idx] = mark_q;
          end
          resp_next.ok = 1'b1;
        end
      end
      KIND_EVICT: begin
        if (found) begin
          tracked_next[best_idx]   = 1'b0;
          can_evict_next[best_idx] = 1'b0;
          if (evict_cnt != '0) begin
            evict_cnt_next = evict_cnt - COUNT_BITS'(1);
          end
          resp_next.ok           = 1'b1;
          resp_next.victim_frame = best_wide[ID_BITS-1:0];
        end
      end
      KIND_REMOVE: begin
        if (!in_range) begin
          resp_next.error = ERR_RANGE;
        end else if (!tracked[idx]) begin
          resp_next.error = ERR_UNTRACKED;
        end else if (!can_evict[idx]) begin
          resp_next.error = ERR_UNEVICTABLE;
        end else begin
          tracked_next[idx]   = 1'b0;
          can_evict_next[idx] = 1'b0;
          if (evict_cnt != '0) begin
            evict_cnt_next = evict_cnt - COUNT_BITS'(1);
          end
          resp_next.ok = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (found) begin
          resp_next.ok           = 1'b1;
          resp_next.victim_frame = best_wide[ID_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
    resp_next.evictable_total = evict_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked      <= '0;
      can_evict    <= '0;
      evict_cnt    <= '0;
      access_clock <= '0;
    end else if (cmd.commit) begin
      tracked      <= tracked_next;
      can_evict    <= can_evict_next;
      evict_cnt    <= evict_cnt_next;
      access_clock <= access_clock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (cmd.commit) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      resp <= resp_next;
    end
  end

endmodule

// ===== rtl/lru_buffer_replacer_core.sv =====
// ----------------------------------------------------------------------------
// lru_buffer_replacer_core
// LRU replacement tracker for a pool of buffer frames.
// ----------------------------------------------------------------------------
// Each request is one operation on the frame table: record an access, set or
// clear a frame's evictable mark, evict the victim, remove a frame, or peek at
// the victim; every request returns exactly one response. Evict and peek run
// the victim scan, which reads one stamp per cycle from the single read port
// of the stamp memory and compares it against the oldest so far; the other
// codes skip the scan. A new request is taken while the previous response
// still waits in the output register; a stalled response delays only the
// commit step. The frame_count register is written on the cfg channel
// (always ready); the user must write it only while the block is idle, and
// the block itself does not enforce this. There is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module lru_buffer_replacer_core #(
  parameter int FRAMES     = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  lbr_pkg::lbr_req_t              req,
  output logic                           resp_valid,
  input  logic                           resp_stall,
  output lbr_pkg::lbr_resp_t             resp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lbr_pkg::COUNT_BITS-1:0] cfg_data
);
  import lbr_pkg::*;

  lbr_cmd_t  cmd;
  lbr_stat_t stat;

  // the config register accepts a write in any cycle
  assign cfg_ready = 1'b1;

  // sequence each request: accept, scan (evict and peek), commit
  lbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // frame table, stamps, access clock and the response register
  lbr_datapath #(
    .FRAMES     (FRAMES),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .req        (req),
    .cmd        (cmd),
    .stat       (stat),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
  );

endmodule

// ===== rtl/lbr_checker.sv =====
// ----------------------------------------------------------------------------
// lbr_checker
// Port-level checks of the LRU buffer replacer, bound to the top level.
// ----------------------------------------------------------------------------
module lbr_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                resp_valid,
  input logic                resp_stall,
  input lbr_pkg::lbr_resp_t  resp
);
  import lbr_pkg::*;

  // a stalled response stays valid
  assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_stall |=> resp_valid)
    else $error("response dropped while stalled");

  // a stalled response holds its payload
  assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_stall |=> $stable(resp))
    else $error("response changed while stalled");

  // an accepted request makes the block busy in the cycle after it
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken two cycles in a row");

  // a new response appears only out of a busy cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(resp_valid) |-> $past(req_stall))
    else $error("response without request in flight");

endmodule

bind lru_buffer_replacer_core lbr_checker u_lbr_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .resp_valid (resp_valid),
  .resp_stall (resp_stall),
  .resp       (resp)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU buffer replacer core. A shadow frame table
// predicts every response from the accepted requests; bursty requests and a
// patterned response stall exercise the handshakes across several frame_count
// settings, including the empty, single-frame and oversize ones.
// ----------------------------------------------------------------------------
module tb;
  import lbr_pkg::*;

  localparam int NFRAMES = 64;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  lbr_req_t  req = '0;
  logic      resp_valid;
  logic      resp_stall = 1'b0;
  lbr_resp_t resp;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [COUNT_BITS-1:0] cfg_data = '0;

  lru_buffer_replacer_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // --------------------------------------------------------------------------
  // Shadow frame table: tracked and evictable marks, stamps, access clock,
  // evictable count and the frame_count setting.
  // --------------------------------------------------------------------------
  logic                  frame_tracked   [NFRAMES];
  logic                  frame_evictable [NFRAMES];
  logic [31:0]           frame_stamp     [NFRAMES];
  logic [31:0]           access_clk;
  logic [COUNT_BITS-1:0] evict_cnt;
  logic [COUNT_BITS-1:0] frame_lim;

  lbr_req_t  pend_q[$];         // requests waiting for the driver
  lbr_resp_t resp_expect_q[$];  // predicted responses, oldest first
  int        errors = 0;

  // Apply one request to the shadow table and return the response it must
  // produce. Ids at or above frame_count are out of range; frames left
  // tracked above a shrunken frame_count still compete for victim.
  function automatic lbr_resp_t predict_op(lbr_req_t r);
    lbr_resp_t  o;
    logic       in_rng;
    logic       found;
    logic [5:0] vic;
    logic [31:0] best;
    o = '0;
    in_rng = ({1'b0, r.frame_id} < frame_lim);
    found = 1'b0;
    vic = '0;
    best = '0;
    if (r.kind == KIND_EVICT || r.kind == KIND_PEEK) begin
      // oldest stamp wins; strict compare keeps the lower id on a tie
      for (int i = 0; i < NFRAMES; i++) begin
        if (frame_tracked[i] && frame_evictable[i] &&
            (!found || frame_stamp[i] < best)) begin
          found = 1'b1;
          best = frame_stamp[i];
          vic = 6'(i);
        end
      end
    end
    case (r.kind)
      KIND_RECORD: begin
        // the clock advances even when the id is rejected, and saturates
        if (access_clk != '1) access_clk = access_clk + 32'd1;
        if (!in_rng) begin
          o.error = ERR_RANGE;
        end else begin
          if (!frame_tracked[r.frame_id]) begin
            frame_tracked[r.frame_id] = 1'b1;
            frame_evictable[r.frame_id] = 1'b0;
          end
          frame_stamp[r.frame_id] = access_clk;
          o.ok = 1'b1;
        end
      end
      KIND_SET_EVICT: begin
        if (!in_rng) begin
          o.error = ERR_RANGE;
        end else if (!frame_tracked[r.frame_id]) begin
          o.error = ERR_UNTRACKED;
        end else begin
          if (frame_evictable[r.frame_id] != r.evictable) begin
            if (r.evictable) evict_cnt = evict_cnt + 7'd1;
            else if (evict_cnt != 0) evict_cnt = evict_cnt - 7'd1;
            frame_evictable[r.frame_id] = r.evictable;
          end
          o.ok = 1'b1;
        end
      end
      KIND_EVICT: begin
        if (found) begin
          frame_tracked[vic] = 1'b0;
          frame_evictable[vic] = 1'b0;
          if (evict_cnt != 0) evict_cnt = evict_cnt - 7'd1;
          o.ok = 1'b1;
          o.victim_frame = vic;
        end
      end
      KIND_REMOVE: begin
        if (!in_rng) begin
          o.error = ERR_RANGE;
        end else if (!frame_tracked[r.frame_id]) begin
          o.error = ERR_UNTRACKED;
        end else if (!frame_evictable[r.frame_id]) begin
          o.error = ERR_UNEVICTABLE;
        end else begin
          frame_tracked[r.frame_id] = 1'b0;
          frame_evictable[r.frame_id] = 1'b0;
          if (evict_cnt != 0) evict_cnt = evict_cnt - 7'd1;
          o.ok = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (found) begin
          o.ok = 1'b1;
          o.victim_frame = vic;
        end
      end
      default: ;  // unused codes change nothing
    endcase
    o.evictable_total = evict_cnt;
    return o;
  endfunction

  // Draw a random request. Most ids come from a small hot set so that frames
  // get recorded, marked and then evicted or removed; the rest spread over
  // the valid range and the full id space.
  function automatic lbr_req_t rand_op(logic [COUNT_BITS-1:0] lim);
    lbr_req_t r;
    int       pick;
    int       span;
    int       hot;
    span = (lim > NFRAMES) ? NFRAMES : int'(lim);
    hot = (span < 12) ? span : 12;
    r.evictable = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 30) r.kind = KIND_RECORD;
    else if (pick < 55) begin
      r.kind = KIND_SET_EVICT;
      r.evictable = ($urandom_range(0, 3) != 0);
    end
    else if (pick < 67) r.kind = KIND_EVICT;
    else if (pick < 80) r.kind = KIND_REMOVE;
    else if (pick < 94) r.kind = KIND_PEEK;
    else r.kind = 3'($urandom_range(5, 7));
    pick = $urandom_range(0, 99);
    if (span == 0 || pick >= 90) r.frame_id = 6'($urandom_range(0, NFRAMES - 1));
    else if (pick < 60) r.frame_id = 6'($urandom_range(0, hot - 1));
    else r.frame_id = 6'($urandom_range(0, span - 1));
    return r;
  endfunction

  task automatic push_op(logic [KIND_BITS-1:0] k, logic [ID_BITS-1:0] id, logic mark);
    lbr_req_t r;
    r.kind = k;
    r.frame_id = id;
    r.evictable = mark;
    pend_q.push_back(r);
  endtask

  // Hold until every queued request went out and every response came back.
  // Sample on the falling edge, where all clocked updates have settled.
  task automatic wait_drained();
    while (pend_q.size() != 0 || req_valid || resp_expect_q.size() != 0)
      @(negedge clk);
  endtask

  // Write frame_count; the block is idle whenever this is called.
  task automatic write_frame_count(logic [COUNT_BITS-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_lim = v;
  endtask

  task automatic run_phase(logic [COUNT_BITS-1:0] lim, int n);
    write_frame_count(lim);
    for (int i = 0; i < n; i++) pend_q.push_back(rand_op(lim));
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Request driver: sends in bursts of random length separated by random
  // gaps. A stalled request holds its payload and valid until accepted.
  // --------------------------------------------------------------------------
  int       burst_left = 1;
  int       gap_left = 0;
  lbr_req_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else begin
      if (req_valid && !req_stall) resp_expect_q.push_back(predict_op(req));
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          req_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          next_req = pend_q.pop_front();
          req       <= next_req;
          req_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left = burst_left - 1;
          end else begin
            // start a new burst; about a quarter of bursts follow without gap
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: checks each accepted response against the oldest
  // prediction, then picks the next stall value. The stall mode switches
  // between no stall, scattered single stalls and long stall runs.
  // --------------------------------------------------------------------------
  int        stall_mode = 0;
  int        mode_left = 0;
  int        run_left = 0;
  logic      stall_nxt;
  lbr_resp_t exp_resp;

  always @(posedge clk) begin
    if (rst) begin
      resp_stall <= 1'b0;
    end else begin
      if (resp_valid && !resp_stall) begin
        if (resp_expect_q.size() == 0) begin
          $error("unexpected response: ok %0d victim_frame %0d error %0d total %0d",
                 resp.ok, resp.victim_frame, resp.error, resp.evictable_total);
          errors++;
        end else begin
          exp_resp = resp_expect_q.pop_front();
          if (resp.ok !== exp_resp.ok) begin
            $error("ok: expected %0d, actual %0d", exp_resp.ok, resp.ok);
            errors++;
          end
          if (resp.victim_frame !== exp_resp.victim_frame) begin
            $error("victim_frame: expected %0d, actual %0d", exp_resp.victim_frame,
                   resp.victim_frame);
            errors++;
          end
          if (resp.error !== exp_resp.error) begin
            $error("error: expected %0d, actual %0d", exp_resp.error, resp.error);
            errors++;
          end
          if (resp.evictable_total !== exp_resp.evictable_total) begin
            $error("evictable_total: expected %0d, actual %0d",
                   exp_resp.evictable_total, resp.evictable_total);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left = mode_left - 1;
      end
      case (stall_mode)
        0: stall_nxt = 1'b0;
        1: stall_nxt = ($urandom_range(0, 2) == 0);
        default: begin
          if (run_left > 0) begin
            run_left = run_left - 1;
            stall_nxt = 1'b1;
          end else if ($urandom_range(0, 7) == 0) begin
            run_left = $urandom_range(1, 20);
            stall_nxt = 1'b1;
          end else begin
            stall_nxt = 1'b0;
          end
        end
      endcase
      resp_stall <= stall_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed requests, then random phases at several frame_count
  // settings. Shrinking leaves frames tracked above the new limit.
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NFRAMES; i++) begin
      frame_tracked[i] = 1'b0;
      frame_evictable[i] = 1'b0;
      frame_stamp[i] = '0;
    end
    access_clk = '0;
    evict_cnt = '0;
    frame_lim = FRAME_COUNT_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_frame_count(FRAME_COUNT_RESET);
    push_op(KIND_PEEK,      6'd0,  1'b0);  // empty table: no victim
    push_op(KIND_EVICT,     6'd63, 1'b1);
    push_op(KIND_RECORD,    6'd0,  1'b1);  // new frame is not evictable
    push_op(KIND_RECORD,    6'd63, 1'b0);
    push_op(KIND_RECORD,    6'd0,  1'b0);  // restamp a tracked frame
    push_op(KIND_SET_EVICT, 6'd5,  1'b1);  // untracked
    push_op(KIND_REMOVE,    6'd5,  1'b0);  // untracked
    push_op(KIND_REMOVE,    6'd0,  1'b0);  // tracked but unevictable
    push_op(KIND_PEEK,      6'd0,  1'b0);  // tracked frames, none evictable
    push_op(KIND_SET_EVICT, 6'd0,  1'b1);
    push_op(KIND_SET_EVICT, 6'd63, 1'b1);
    push_op(KIND_SET_EVICT, 6'd63, 1'b1);  // same mark again: count holds
    push_op(KIND_RECORD,    6'd63, 1'b0);  // restamp keeps the mark
    push_op(KIND_PEEK,      6'd0,  1'b1);
    push_op(KIND_EVICT,     6'd0,  1'b0);
    push_op(KIND_SET_EVICT, 6'd63, 1'b0);
    push_op(KIND_PEEK,      6'd0,  1'b0);
    push_op(KIND_SET_EVICT, 6'd63, 1'b1);
    push_op(KIND_REMOVE,    6'd63, 1'b1);
    push_op(KIND_EVICT,     6'd0,  1'b0);
    push_op(3'd5,           6'd42, 1'b1);  // unused codes
    push_op(3'd6,           6'd21, 1'b0);
    push_op(3'd7,           6'd63, 1'b1);
    wait_drained();

    // out-of-range ids at the single-frame setting; oversize acts as full
    write_frame_count(7'd1);
    push_op(KIND_RECORD,    6'd1,  1'b0);
    push_op(KIND_SET_EVICT, 6'd63, 1'b1);
    push_op(KIND_REMOVE,    6'd32, 1'b1);
    push_op(KIND_RECORD,    6'd0,  1'b0);
    wait_drained();

    run_phase(FRAME_COUNT_RESET, 140);
    run_phase(7'd1, 30);
    run_phase(7'd0, 20);
    run_phase(7'd127, 80);
    run_phase(7'($urandom_range(2, 63)), 80);
    run_phase(7'd8, 50);

    // let the slowest request (a full victim scan) finish before judging
    repeat (2 * NFRAMES + 16) @(posedge clk);
    if (resp_expect_q.size() != 0) begin
      $error("%0d responses never arrived", resp_expect_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: declares failure if the run has not finished in time.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lbr_pkg.sv
rtl/lbr_ctrl.sv
rtl/lbr_datapath.sv
rtl/lru_buffer_replacer_core.sv
rtl/lbr_checker.sv
sim/tb.sv
